// ===== src/averaged_period_to_rpm_macros.svh =====
// ----------------------------------------------------------------------------
// averaged_period_to_rpm_macros.svh
// Assertion macros used by the tachometer sequencer RTL. SYNTH drops them to nothing.
// ----------------------------------------------------------------------------
`ifndef AVERAGED_PERIOD_TO_RPM_MACROS_SVH
`define AVERAGED_PERIOD_TO_RPM_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define APR_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define APR_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define APR_ASSERT_NOW(label, pre, post, msg)
`define APR_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// ===== src/apr_pkg.sv =====
// ----------------------------------------------------------------------------
// apr_pkg
// Constants and controller/datapath interface types for the tachometer.
// ----------------------------------------------------------------------------
package apr_pkg;

    localparam int PULSES_PER_AVERAGE = 8;    // 1 .. 256
    localparam int FRACTION_BITS      = 8;    // 0 .. 16

    localparam int SCALE_W  = 32;
    localparam int PERIOD_W = 32;
    localparam int SUM_W    = 40;
    localparam int SPEED_W  = 40;
    localparam int CNT_W    = 8;

    // dividend is scale << FRACTION_BITS; quotient register covers it and speed
    localparam int NUMER_W = SCALE_W + FRACTION_BITS;
    localparam int QUOT_W  = (NUMER_W > SPEED_W) ? NUMER_W : SPEED_W;
    localparam int ITER_W  = $clog2(QUOT_W);

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(60000000);

    typedef struct packed {
        logic accumulate;   // add period, bump count
        logic start;        // last period of block: load divider, clear sum
        logic step;         // one restoring divide step
        logic load_out;     // move result into output register
    } apr_cmd_t;

    typedef struct packed {
        logic last_pulse;   // incoming period closes the block
        logic sum_zero;     // block sum including incoming period is zero
    } apr_status_t;

endpackage

// ===== src/apr_ctrl.sv =====
// ----------------------------------------------------------------------------
// apr_ctrl
// Sequencer: accumulate, run the divider, hand the result to the output.
// ----------------------------------------------------------------------------
`include "averaged_period_to_rpm_macros.svh"

module apr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  apr_pkg::apr_status_t status,
    output apr_pkg::apr_cmd_t    cmd
);
    import apr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic                out_valid_reg, out_valid_next;
    logic                in_accept;
    logic                out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (status.last_pulse)
                    begin
                        cmd.start = 1'b1;
                        iter_next = ITER_W'(QUOT_W - 1);
                        // zero sum needs no division
                        state_next = status.sum_zero ? S_HOLD : S_DIV;
                    end
                    else
                    begin
                        cmd.accumulate = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                if (iter_reg == '0)
                begin
                    state_next = S_HOLD;
                end
                else
                begin
                    iter_next = iter_reg - 1'b1;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `APR_ASSERT_NOW(a_load_only_when_free, cmd.load_out, out_free, "result loaded over pending one")
    `APR_ASSERT_NEXT(a_start_blocks_input, cmd.start, in_stall, "input open during division")
    `APR_ASSERT_NEXT(a_iter_counts_down, (state_reg == S_DIV) && (iter_reg != '0), (state_reg == S_DIV) && (iter_reg == $past(iter_reg) - 1'b1), "divide step count skipped")
    `APR_ASSERT_NEXT(a_load_shows_valid, cmd.load_out, out_valid, "loaded result not presented")

endmodule

// ===== src/apr_datapath.sv =====
// ----------------------------------------------------------------------------
// apr_datapath
// Period sum/count, scale register, restoring divider, output register.
// ----------------------------------------------------------------------------
module apr_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [apr_pkg::SCALE_W-1:0]   cfg_wr_data,
    input  logic [apr_pkg::PERIOD_W-1:0]  pulse_period,
    input  apr_pkg::apr_cmd_t             cmd,
    output apr_pkg::apr_status_t          status,
    output logic [apr_pkg::SPEED_W-1:0]   speed_rpm,
    output logic                          zero_period
);
    import apr_pkg::*;

    localparam logic [QUOT_W-1:0] SPEED_MAX_Q = QUOT_W'({SPEED_W{1'b1}});

    logic [SCALE_W-1:0] rpm_scale_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W:0]     count_inc;

    logic [QUOT_W-1:0]  quot_reg, quot_next;
    logic [SUM_W-1:0]   rem_reg, rem_next;
    logic [SUM_W-1:0]   divisor_reg, divisor_next;
    logic               zero_reg, zero_next;
    logic [SUM_W:0]     trial;
    logic [SUM_W:0]     trial_diff;
    logic               trial_ge;

    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic               zero_out_reg, zero_out_next;

    logic [SUM_W-1:0]   sum_in;

    assign sum_in    = sum_reg + SUM_W'(pulse_period);
    assign count_inc = {1'b0, count_reg} + 1'b1;

    assign status.last_pulse = (count_inc >= (CNT_W+1)'(PULSES_PER_AVERAGE));
    assign status.sum_zero   = (sum_in == '0);

    // restoring step: shift in next dividend bit, subtract if it fits
    assign trial      = {rem_reg, quot_reg[QUOT_W-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign trial_ge   = !trial_diff[SUM_W];

    always_comb
    begin
        sum_next      = sum_reg;
        count_next    = count_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        divisor_next  = divisor_reg;
        zero_next     = zero_reg;
        speed_next    = speed_reg;
        zero_out_next = zero_out_reg;

        if (cmd.accumulate)
        begin
            sum_next   = sum_in;
            count_next = count_inc[CNT_W-1:0];
        end

        if (cmd.start)
        begin
            sum_next     = '0;
            count_next   = '0;
            divisor_next = sum_in;
            zero_next    = (sum_in == '0);
            rem_next     = '0;
            quot_next    = QUOT_W'(rpm_scale_reg) << FRACTION_BITS;
        end

        if (cmd.step)
        begin
            rem_next  = trial_ge ? trial_diff[SUM_W-1:0] : trial[SUM_W-1:0];
            quot_next = {quot_reg[QUOT_W-2:0], trial_ge};
        end

        if (cmd.load_out)
        begin
            zero_out_next = zero_reg;
            if (zero_reg || (quot_reg > SPEED_MAX_Q))
            begin
                speed_next = '1;
            end
            else
            begin
                speed_next = quot_reg[SPEED_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_scale_reg <= SCALE_RESET;
            sum_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                rpm_scale_reg <= cfg_wr_data;
            end
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        zero_reg     <= zero_next;
        speed_reg    <= speed_next;
        zero_out_reg <= zero_out_next;
    end

    assign speed_rpm   = speed_reg;
    assign zero_period = zero_out_reg;

endmodule

// ===== src/averaged_period_to_rpm.sv =====
// ----------------------------------------------------------------------------
// averaged_period_to_rpm
// Period-averaging tachometer: block of periods in, one speed request out.
// ----------------------------------------------------------------------------
// Each input request carries one pulse period in timer ticks. Periods are
// summed; every PULSES_PER_AVERAGE periods (8 by default) the block emits one
// speed request, (rpm_scale << FRACTION_BITS) / sum, truncated, with
// FRACTION_BITS fraction bits. A zero sum gives an all-ones speed with
// zero_period set; a quotient too wide for 40 bits saturates to all ones.
// The closing period starts a restoring divider that retires one quotient bit
// per cycle for a QUOT_W = max(32 + FRACTION_BITS, 40) bit quotient (40 bits
// by default), then loads the output register once it is free. The input is
// stalled while the divider runs and the result waits; a zero sum skips the
// divider. Input is also accepted while a finished speed waits on a stalled
// output; only a new result waits for the output register to drain.
// rpm_scale resets to 60,000,000 and is written with cfg_wr_en/cfg_wr_data;
// the user must write it only while the block is idle, which the block does
// not enforce.
// ----------------------------------------------------------------------------
module averaged_period_to_rpm (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [apr_pkg::SCALE_W-1:0]   cfg_wr_data,
    // period requests
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [apr_pkg::PERIOD_W-1:0]  pulse_period,
    // speed requests
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [apr_pkg::SPEED_W-1:0]   speed_rpm,
    output logic                          zero_period
);
    import apr_pkg::*;

    apr_cmd_t    cmd;
    apr_status_t status;

    // sequencer: owns handshakes, state and the divide step count
    apr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // accumulator, scale register, divider and output register
    apr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .pulse_period (pulse_period),
        .cmd          (cmd),
        .status       (status),
        .speed_rpm    (speed_rpm),
        .zero_period  (zero_period)
    );

endmodule
